/* src/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, codes and helper functions of the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_in_string;
    } sed_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] error_kind;
        logic       last_of_run;
        logic       end_of_string;
    } sed_out_t;

    // Up to four decoded bytes caused by one input byte
    localparam int unsigned RES_MAX = 4;

    typedef struct packed {
        logic [2:0]               count;
        logic [RES_MAX-1:0][7:0]  bytes;
        logic [RES_MAX-1:0][3:0]  errs;
    } res_list_t;

    typedef enum logic [6:0] {
        MODE_PLAIN     = 7'b0000001,
        MODE_ESC       = 7'b0000010,
        MODE_NUM_START = 7'b0000100,
        MODE_NUM       = 7'b0001000,
        MODE_U_BRACE   = 7'b0010000,
        MODE_U_DIGITS  = 7'b0100000,
        MODE_DROP      = 7'b1000000
    } scan_mode_t;

    localparam logic [1:0] KIND_BIN = 2'd0;
    localparam logic [1:0] KIND_OCT = 2'd1;
    localparam logic [1:0] KIND_HEX = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_MISSING    = 4'd1;
    localparam logic [3:0] ERR_OCT_RANGE  = 4'd2;
    localparam logic [3:0] ERR_NO_OPEN    = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX    = 4'd4;
    localparam logic [3:0] ERR_TOO_MANY   = 4'd5;
    localparam logic [3:0] ERR_EMPTY      = 4'd6;
    localparam logic [3:0] ERR_NO_CLOSE   = 4'd7;
    localparam logic [3:0] ERR_BAD_CP     = 4'd8;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_O   = 8'h6F;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [23:0] CP_MAX1   = 24'h00007F;
    localparam logic [23:0] CP_MAX2   = 24'h0007FF;
    localparam logic [23:0] CP_MAX3   = 24'h00FFFF;
    localparam logic [23:0] CP_MAX    = 24'h10FFFF;
    localparam logic [23:0] CP_SUR_LO = 24'h00D800;
    localparam logic [23:0] CP_SUR_HI = 24'h00DFFF;
    localparam logic [23:0] OCT_LIMIT = 24'h0000FF;
    localparam logic [3:0]  U_DIGITS  = 4'd6;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [4:0] digit_val(input logic [1:0] kind, input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        unique case (kind)
            KIND_BIN: r = {(c == CH_ZERO) || (c == CH_ONE), 3'd0, c[0]};
            KIND_OCT: r = {(c >= CH_ZERO) && (c <= CH_SEVEN), 1'b0, c[2:0]};
            default:  r = hex_val(c);
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kind_max(input logic [1:0] kind);
        logic [3:0] r;
        unique case (kind)
            KIND_BIN: r = 4'd8;
            KIND_OCT: r = 4'd3;
            default:  r = 4'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kind_letter(input logic [1:0] kind);
        logic [7:0] r;
        unique case (kind)
            KIND_BIN: r = CH_LO_B;
            KIND_OCT: r = CH_LO_O;
            default:  r = CH_LO_X;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] shift_in(input logic [1:0] kind, input logic [23:0] acc,
                                             input logic [3:0] d);
        logic [23:0] r;
        unique case (kind)
            KIND_BIN: r = {acc[22:0], 1'b0} + {20'd0, d};
            KIND_OCT: r = {acc[20:0], 3'd0} + {20'd0, d};
            default:  r = {acc[19:0], 4'd0} + {20'd0, d};
        endcase
        return r;
    endfunction

    function automatic res_list_t push(input res_list_t l, input logic [7:0] b,
                                       input logic [3:0] e);
        res_list_t r;
        r = l;
        if (l.count < 3'(RES_MAX)) begin
            r.bytes[l.count[1:0]] = b;
            r.errs[l.count[1:0]]  = e;
            r.count               = l.count + 3'd1;
        end
        return r;
    endfunction

    function automatic logic num_over(input logic [1:0] kind, input logic [23:0] acc);
        return (kind == KIND_OCT) && (acc > OCT_LIMIT);
    endfunction

    function automatic logic cp_bad(input logic [23:0] v);
        return (v > CP_MAX) || ((v >= CP_SUR_LO) && (v <= CP_SUR_HI));
    endfunction

    function automatic res_list_t utf8_push(input res_list_t l, input logic [23:0] v);
        res_list_t r;
        r = l;
        if (v <= CP_MAX1) begin
            r = push(r, v[7:0], ERR_NONE);
        end else if (v <= CP_MAX2) begin
            r = push(r, {3'b110, v[10:6]}, ERR_NONE);
            r = push(r, {2'b10, v[5:0]}, ERR_NONE);
        end else if (v <= CP_MAX3) begin
            r = push(r, {4'b1110, v[15:12]}, ERR_NONE);
            r = push(r, {2'b10, v[11:6]}, ERR_NONE);
            r = push(r, {2'b10, v[5:0]}, ERR_NONE);
        end else begin
            r = push(r, {5'b11110, v[20:18]}, ERR_NONE);
            r = push(r, {2'b10, v[17:12]}, ERR_NONE);
            r = push(r, {2'b10, v[11:6]}, ERR_NONE);
            r = push(r, {2'b10, v[5:0]}, ERR_NONE);
        end
        return r;
    endfunction

endpackage

/* src/string_escape_decoder.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes the bytes of a string literal, one request a cycle while chr_ready
// is high, into plain bytes, UTF-8 sequences and error codes.
// ----------------------------------------------------------------------------
//  channel | direction | payload          | handshake
//  chr     | in        | sed_in_t         | chr_valid / chr_ready
//  dec     | out       | sed_out_t        | dec_valid / dec_ready
//  cfg     | in        | strict bit       | cfg_valid / cfg_ready (always ready)
//
//  One request is decoded in the cycle it is accepted; its results, at most
//  4, leave from a result register one per cycle while dec_ready is high.
//  A second result list waits in a holding register while the first drains.
//  chr_ready drops only while that holding register is full.
//  Reset clears the scan state and sets the strict bit.
// ----------------------------------------------------------------------------
module string_escape_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              chr_valid,
    output logic              chr_ready,
    input  sed_pkg::sed_in_t  chr_data,
    output logic              dec_valid,
    input  logic              dec_ready,
    output sed_pkg::sed_out_t dec_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import sed_pkg::*;

    scan_mode_t  mode_reg, mode_next;
    logic [23:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  kind_reg, kind_next;
    logic        strict_reg;

    res_list_t   lst;
    logic [4:0]  dig;
    logic [4:0]  hex;
    logic [3:0]  cnt_inc;
    logic [23:0] acc_shift;
    logic [7:0]  c;

    res_list_t   a_list_reg;
    logic [1:0]  a_ptr_reg;
    logic [2:0]  a_left_reg;
    logic        a_end_reg;
    res_list_t   b_list_reg;
    logic        b_end_reg;
    logic        b_valid_reg;

    logic        chr_fire;
    logic        dec_fire;
    logic        a_free;
    logic        load_a_b;
    logic        load_a_in;
    logic        load_b;

    assign c         = chr_data.char_byte;
    assign cfg_ready = 1'b1;
    assign chr_ready = !b_valid_reg;
    assign chr_fire  = chr_valid && chr_ready;
    assign dec_valid = (a_left_reg != 3'd0);
    assign dec_fire  = dec_valid && dec_ready;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        lst       = '0;
        dig       = digit_val(kind_reg, c);
        hex       = hex_val(c);
        cnt_inc   = cnt_reg + 4'd1;
        acc_shift = shift_in(kind_reg, acc_reg, dig[3:0]);

        unique case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                case (c) inside
                    CH_LO_N: lst = push(lst, CH_LF, ERR_NONE);
                    CH_LO_T: lst = push(lst, CH_TAB, ERR_NONE);
                    CH_LO_R: lst = push(lst, CH_CR, ERR_NONE);
                    CH_BSLASH, CH_QUOTE, CH_BTICK, CH_PCT: lst = push(lst, c, ERR_NONE);
                    CH_LO_B, CH_LO_O, CH_LO_X:
                    begin
                        kind_next = (c == CH_LO_B) ? KIND_BIN :
                                    (c == CH_LO_O) ? KIND_OCT : KIND_HEX;
                        acc_next  = '0;
                        cnt_next  = '0;
                        mode_next = MODE_NUM_START;
                    end
                    CH_LO_U:
                    begin
                        acc_next  = '0;
                        cnt_next  = '0;
                        mode_next = MODE_U_BRACE;
                    end
                    default:
                    begin
                        lst = push(lst, CH_BSLASH, ERR_NONE);
                        lst = push(lst, c, ERR_NONE);
                    end
                endcase
            end
            MODE_NUM_START:
            begin
                if (dig[4]) begin
                    acc_next  = {20'd0, dig[3:0]};
                    cnt_next  = 4'd1;
                    mode_next = MODE_NUM;
                end else if (strict_reg) begin
                    lst       = push(lst, 8'h00, ERR_MISSING);
                    mode_next = MODE_DROP;
                end else begin
                    lst = push(lst, CH_BSLASH, ERR_NONE);
                    lst = push(lst, kind_letter(kind_reg), ERR_NONE);
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        mode_next = MODE_PLAIN;
                        lst       = push(lst, c, ERR_NONE);
                    end
                end
            end
            MODE_NUM:
            begin
                if (dig[4] && (cnt_reg < kind_max(kind_reg))) begin
                    acc_next  = acc_shift;
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= kind_max(kind_reg)) begin
                        if (num_over(kind_reg, acc_shift)) begin
                            lst       = push(lst, 8'h00, ERR_OCT_RANGE);
                            mode_next = MODE_DROP;
                        end else begin
                            lst       = push(lst, acc_shift[7:0], ERR_NONE);
                            mode_next = MODE_PLAIN;
                        end
                    end
                end else if (num_over(kind_reg, acc_reg)) begin
                    lst       = push(lst, 8'h00, ERR_OCT_RANGE);
                    mode_next = MODE_DROP;
                end else begin
                    lst = push(lst, acc_reg[7:0], ERR_NONE);
                    if (c == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        mode_next = MODE_PLAIN;
                        lst       = push(lst, c, ERR_NONE);
                    end
                end
            end
            MODE_U_BRACE:
            begin
                if (c == CH_LBRACE) begin
                    mode_next = MODE_U_DIGITS;
                end else begin
                    lst       = push(lst, 8'h00, ERR_NO_OPEN);
                    mode_next = MODE_DROP;
                end
            end
            MODE_U_DIGITS:
            begin
                if (hex[4]) begin
                    if (cnt_reg >= U_DIGITS) begin
                        lst       = push(lst, 8'h00, ERR_TOO_MANY);
                        mode_next = MODE_DROP;
                    end else begin
                        acc_next = {acc_reg[19:0], hex[3:0]};
                        cnt_next = cnt_inc;
                    end
                end else if (c == CH_RBRACE) begin
                    if (cnt_reg == 4'd0) begin
                        lst       = push(lst, 8'h00, ERR_EMPTY);
                        mode_next = MODE_DROP;
                    end else if (cp_bad(acc_reg)) begin
                        lst       = push(lst, 8'h00, ERR_BAD_CP);
                        mode_next = MODE_DROP;
                    end else begin
                        lst       = utf8_push(lst, acc_reg);
                        mode_next = MODE_PLAIN;
                    end
                end else begin
                    lst       = push(lst, 8'h00, ERR_BAD_HEX);
                    mode_next = MODE_DROP;
                end
            end
            MODE_DROP:
            begin
                mode_next = MODE_DROP;
            end
            default:
            begin
                if (c == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_PLAIN;
                    lst       = push(lst, c, ERR_NONE);
                end
            end
        endcase

        // flush any pending escape at the end of the literal
        if (chr_data.last_in_string) begin
            unique case (mode_next)
                MODE_ESC:
                begin
                    lst = push(lst, CH_BSLASH, ERR_NONE);
                end
                MODE_NUM_START:
                begin
                    if (strict_reg) begin
                        lst = push(lst, 8'h00, ERR_MISSING);
                    end else begin
                        lst = push(lst, CH_BSLASH, ERR_NONE);
                        lst = push(lst, kind_letter(kind_next), ERR_NONE);
                    end
                end
                MODE_NUM:
                begin
                    if (num_over(kind_next, acc_next)) begin
                        lst = push(lst, 8'h00, ERR_OCT_RANGE);
                    end else begin
                        lst = push(lst, acc_next[7:0], ERR_NONE);
                    end
                end
                MODE_U_BRACE:
                begin
                    lst = push(lst, 8'h00, ERR_NO_OPEN);
                end
                MODE_U_DIGITS:
                begin
                    lst = push(lst, 8'h00, (cnt_next == 4'd0) ? ERR_EMPTY : ERR_NO_CLOSE);
                end
                default:
                begin
                    lst = lst;
                end
            endcase
            mode_next = MODE_PLAIN;
            acc_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_PLAIN;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            kind_reg   <= KIND_BIN;
            strict_reg <= 1'b1;
        end else begin
            if (chr_fire) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                kind_reg <= kind_next;
            end
            if (cfg_valid && cfg_ready) begin
                strict_reg <= cfg_data;
            end
        end
    end

    // result register (A) drains while the holding register (B) waits
    assign a_free    = (a_left_reg == 3'd0) || ((a_left_reg == 3'd1) && dec_fire);
    assign load_a_b  = a_free && b_valid_reg;
    assign load_a_in = a_free && !b_valid_reg && chr_fire;
    assign load_b    = chr_fire && !a_free && (lst.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_left_reg  <= '0;
            a_ptr_reg   <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            if (load_a_b) begin
                a_left_reg <= b_list_reg.count;
                a_ptr_reg  <= '0;
            end else if (load_a_in) begin
                a_left_reg <= lst.count;
                a_ptr_reg  <= '0;
            end else if (dec_fire) begin
                a_left_reg <= a_left_reg - 3'd1;
                a_ptr_reg  <= a_ptr_reg + 2'd1;
            end
            if (load_b) begin
                b_valid_reg <= 1'b1;
            end else if (load_a_b) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a_b) begin
            a_list_reg <= b_list_reg;
            a_end_reg  <= b_end_reg;
        end else if (load_a_in) begin
            a_list_reg <= lst;
            a_end_reg  <= chr_data.last_in_string;
        end
        if (load_b) begin
            b_list_reg <= lst;
            b_end_reg  <= chr_data.last_in_string;
        end
    end

    assign dec_data.data_byte     = a_list_reg.bytes[a_ptr_reg];
    assign dec_data.error_kind    = a_list_reg.errs[a_ptr_reg];
    assign dec_data.last_of_run   = (a_left_reg == 3'd1);
    assign dec_data.end_of_string = a_end_reg;

endmodule

/* src/sed_checker.sv */
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks of the string escape decoder, bound to its top level.
// ----------------------------------------------------------------------------
module sed_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              chr_valid,
    input logic              chr_ready,
    input sed_pkg::sed_in_t  chr_data,
    input logic              dec_valid,
    input logic              dec_ready,
    input sed_pkg::sed_out_t dec_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              cfg_data
);
    import sed_pkg::*;

    logic unused_inputs;
    assign unused_inputs = chr_valid ^ cfg_valid ^ cfg_ready ^ cfg_data ^ (^chr_data);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(dec_data))
        else $error("stalled result changed or dropped");

    // stall the input only while results are waiting
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !chr_ready |-> dec_valid)
        else $error("input stalled with no pending result");

    // an error result carries a zero byte and closes its run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && (dec_data.error_kind != ERR_NONE) |->
            (dec_data.data_byte == 8'h00) && dec_data.last_of_run)
        else $error("error result not final or byte not zero");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid |-> (dec_data.error_kind <= ERR_BAD_CP))
        else $error("error code out of range");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);

/* tb/sv/sed_check_pkg.sv */
// ----------------------------------------------------------------------------
// sed_check_pkg
// Scoreboard of the string escape decoder test. It follows the scan state
// through every accepted request, predicts the decoded bytes and error codes
// that the request causes, and compares each decoded result in order.
// ----------------------------------------------------------------------------
package sed_check_pkg;

    import sed_pkg::*;

    class escape_scoreboard;

        scan_mode_t  mode;
        logic [23:0] acc;
        logic [3:0]  ndig;
        logic [1:0]  kind;
        logic        strict;
        sed_out_t    decoded_q[$];
        sed_out_t    run_q[$];
        int          live_items;
        int          mismatches;

        function new();
            mode       = MODE_PLAIN;
            acc        = '0;
            ndig       = '0;
            kind       = KIND_BIN;
            strict     = 1'b1;
            live_items = 0;
            mismatches = 0;
        endfunction

        function void set_strict(logic v);
            strict = v;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void put(logic [7:0] b, logic [3:0] e);
            sed_out_t r;
            if (run_q.size() < RES_MAX)
            begin
                r.data_byte     = b;
                r.error_kind    = e;
                r.last_of_run   = 1'b0;
                r.end_of_string = 1'b0;
                run_q.push_back(r);
            end
        endfunction

        function void abort(logic [3:0] e);
            put(8'h00, e);
            mode = MODE_DROP;
        endfunction

        function int digit_value(logic [1:0] k, logic [7:0] c);
            if (k == KIND_BIN)
                return (c == CH_ZERO || c == CH_ONE) ? int'(c) - int'(CH_ZERO) : -1;
            if (k == KIND_OCT)
                return (c >= CH_ZERO && c <= CH_SEVEN) ? int'(c) - int'(CH_ZERO) : -1;
            if (c >= CH_ZERO && c <= CH_NINE)
                return int'(c) - int'(CH_ZERO);
            if (c >= CH_LO_A && c <= CH_LO_F)
                return int'(c) - int'(CH_LO_A) + 10;
            if (c >= CH_UP_A && c <= CH_UP_F)
                return int'(c) - int'(CH_UP_A) + 10;
            return -1;
        endfunction

        function int digit_limit();
            if (kind == KIND_BIN)
                return 8;
            if (kind == KIND_OCT)
                return 3;
            return 2;
        endfunction

        function void plain(logic [7:0] c);
            if (c == CH_BSLASH)
                mode = MODE_ESC;
            else
                put(c, ERR_NONE);
        endfunction

        function void end_number();
            if (kind == KIND_OCT && acc > OCT_LIMIT)
            begin
                abort(ERR_OCT_RANGE);
                return;
            end
            put(acc[7:0], ERR_NONE);
            mode = MODE_PLAIN;
        endfunction

        function void no_digits();
            if (strict)
            begin
                abort(ERR_MISSING);
                return;
            end
            put(CH_BSLASH, ERR_NONE);
            put(kind == KIND_BIN ? CH_LO_B : kind == KIND_OCT ? CH_LO_O : CH_LO_X, ERR_NONE);
            mode = MODE_PLAIN;
        endfunction

        function void take(int d);
            int sh;
            sh   = (kind == KIND_BIN) ? 1 : (kind == KIND_OCT) ? 3 : 4;
            acc  = (acc << sh) + 24'(d);
            ndig = ndig + 4'd1;
            mode = MODE_NUM;
            if (int'(ndig) >= digit_limit())
                end_number();
        endfunction

        function void close_unicode();
            if (ndig == 0)
            begin
                abort(ERR_EMPTY);
                return;
            end
            if (acc > CP_MAX || (acc >= CP_SUR_LO && acc <= CP_SUR_HI))
            begin
                abort(ERR_BAD_CP);
                return;
            end
            if (acc <= CP_MAX1)
            begin
                put(acc[7:0], ERR_NONE);
            end
            else if (acc <= CP_MAX2)
            begin
                put(8'hC0 | 8'(acc[10:6]), ERR_NONE);
                put(8'h80 | 8'(acc[5:0]), ERR_NONE);
            end
            else if (acc <= CP_MAX3)
            begin
                put(8'hE0 | 8'(acc[15:12]), ERR_NONE);
                put(8'h80 | 8'(acc[11:6]), ERR_NONE);
                put(8'h80 | 8'(acc[5:0]), ERR_NONE);
            end
            else
            begin
                put(8'hF0 | 8'(acc[20:18]), ERR_NONE);
                put(8'h80 | 8'(acc[17:12]), ERR_NONE);
                put(8'h80 | 8'(acc[11:6]), ERR_NONE);
                put(8'h80 | 8'(acc[5:0]), ERR_NONE);
            end
            mode = MODE_PLAIN;
        endfunction

        function void flush();
            case (mode)
                MODE_ESC:       put(CH_BSLASH, ERR_NONE);
                MODE_NUM_START: no_digits();
                MODE_NUM:       end_number();
                MODE_U_BRACE:   abort(ERR_NO_OPEN);
                MODE_U_DIGITS:  abort(ndig == 0 ? ERR_EMPTY : ERR_NO_CLOSE);
                default:        ;
            endcase
            mode = MODE_PLAIN;
            acc  = '0;
            ndig = '0;
        endfunction

        function void note_request(sed_in_t req);
            logic [7:0] c;
            int         d;
            c = req.char_byte;
            run_q.delete();
            if (mode != MODE_DROP)
                live_items++;
            case (mode)
                MODE_ESC:
                begin
                    mode = MODE_PLAIN;
                    case (c)
                        CH_LO_N: put(CH_LF, ERR_NONE);
                        CH_LO_T: put(CH_TAB, ERR_NONE);
                        CH_LO_R: put(CH_CR, ERR_NONE);
                        CH_BSLASH, CH_QUOTE, CH_BTICK, CH_PCT: put(c, ERR_NONE);
                        CH_LO_B, CH_LO_O, CH_LO_X:
                        begin
                            kind = (c == CH_LO_B) ? KIND_BIN : (c == CH_LO_O) ? KIND_OCT : KIND_HEX;
                            acc  = '0;
                            ndig = '0;
                            mode = MODE_NUM_START;
                        end
                        CH_LO_U:
                        begin
                            acc  = '0;
                            ndig = '0;
                            mode = MODE_U_BRACE;
                        end
                        default:
                        begin
                            put(CH_BSLASH, ERR_NONE);
                            put(c, ERR_NONE);
                        end
                    endcase
                end
                MODE_NUM_START:
                begin
                    d = digit_value(kind, c);
                    if (d >= 0)
                    begin
                        acc  = '0;
                        ndig = '0;
                        take(d);
                    end
                    else
                    begin
                        no_digits();
                        if (mode == MODE_PLAIN)
                            plain(c);
                    end
                end
                MODE_NUM:
                begin
                    d = digit_value(kind, c);
                    if (d >= 0 && int'(ndig) < digit_limit())
                    begin
                        take(d);
                    end
                    else
                    begin
                        end_number();
                        if (mode == MODE_PLAIN)
                            plain(c);
                    end
                end
                MODE_U_BRACE:
                begin
                    if (c == CH_LBRACE)
                        mode = MODE_U_DIGITS;
                    else
                        abort(ERR_NO_OPEN);
                end
                MODE_U_DIGITS:
                begin
                    d = digit_value(KIND_HEX, c);
                    if (d >= 0)
                    begin
                        if (ndig >= U_DIGITS)
                        begin
                            abort(ERR_TOO_MANY);
                        end
                        else
                        begin
                            acc  = (acc << 4) + 24'(d);
                            ndig = ndig + 4'd1;
                        end
                    end
                    else if (c == CH_RBRACE)
                    begin
                        close_unicode();
                    end
                    else
                    begin
                        abort(ERR_BAD_HEX);
                    end
                end
                MODE_DROP: ;
                default:
                begin
                    mode = MODE_PLAIN;
                    plain(c);
                end
            endcase
            if (req.last_in_string)
                flush();
            foreach (run_q[i])
            begin
                run_q[i].last_of_run   = (i == run_q.size() - 1);
                run_q[i].end_of_string = req.last_in_string;
                decoded_q.push_back(run_q[i]);
            end
        endfunction

        task report(string msg);
            if (mismatches < 30)
                $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(sed_out_t got);
            sed_out_t want;
            if (decoded_q.size() == 0)
            begin
                report($sformatf("unexpected result data_byte %02h error_kind %0d",
                                 got.data_byte, got.error_kind));
                return;
            end
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte %02h, expected %02h", got.data_byte, want.data_byte));
            if (got.error_kind !== want.error_kind)
                report($sformatf("error_kind %0d, expected %0d", got.error_kind,
                                 want.error_kind));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, expected %b", got.last_of_run,
                                 want.last_of_run));
            if (got.end_of_string !== want.end_of_string)
                report($sformatf("end_of_string %b, expected %b", got.end_of_string,
                                 want.end_of_string));
        endtask

    endclass

endpackage

/* tb/sv/string_escape_decoder_test.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder_test
// Feeds string literals through the escape decoder: a short directed set of
// corner cases, then random literals built from plain bytes, simple, unknown,
// numeric and unicode escapes, under both settings of the strict bit, with
// random stalls on both channels. Every decoded result is checked in order.
// ----------------------------------------------------------------------------
module string_escape_decoder_test;

    import sed_pkg::*;
    import sed_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 105;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     chr_valid = 1'b0;
    sed_in_t  chr_data  = '0;
    logic     dec_ready = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     chr_ready;
    logic     dec_valid;
    logic     cfg_ready;
    sed_out_t dec_data;

    escape_scoreboard sb = new();
    logic [7:0]       text_q[$];
    bit               hold_req = 1'b0;
    bit               holding  = 1'b0;

    always #2 clk = ~clk;

    string_escape_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr_data  (chr_data),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_data  (dec_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return (($urandom_range(0, 1) != 0) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_segment();
        logic [23:0] cp;
        logic [1:0]  k;
        int          n;
        int          w;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            repeat ($urandom_range(1, 3))
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 40)
        begin
            text_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 6))
                0:       text_q.push_back(CH_LO_N);
                1:       text_q.push_back(CH_LO_T);
                2:       text_q.push_back(CH_LO_R);
                3:       text_q.push_back(CH_BSLASH);
                4:       text_q.push_back(CH_QUOTE);
                5:       text_q.push_back(CH_BTICK);
                default: text_q.push_back(CH_PCT);
            endcase
        end
        else if (r < 47)
        begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 70)
        begin
            k = 2'($urandom_range(0, 2));
            text_q.push_back(CH_BSLASH);
            text_q.push_back(k == KIND_BIN ? CH_LO_B : k == KIND_OCT ? CH_LO_O : CH_LO_X);
            w = (k == KIND_BIN) ? 8 : (k == KIND_OCT) ? 3 : 2;
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, w + 1);
            repeat (n)
            begin
                if (k == KIND_BIN)
                    text_q.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
                else if (k == KIND_OCT)
                    text_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
                else
                    text_q.push_back(hex_char($urandom_range(0, 15)));
            end
        end
        else if (r < 95)
        begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_LO_U);
            if ($urandom_range(0, 19) != 0)
            begin
                text_q.push_back(CH_LBRACE);
                case ($urandom_range(0, 6))
                    0: cp = 24'($urandom_range(0, 'h7F));
                    1: cp = 24'($urandom_range('h80, 'h7FF));
                    2: cp = 24'($urandom_range('h800, 'hFFFF));
                    3: cp = 24'($urandom_range('h10000, 'h10FFFF));
                    4: cp = 24'($urandom_range('hD800, 'hDFFF));
                    5: cp = 24'($urandom_range('h110000, 'hFFFFFF));
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0:       cp = CP_MAX1;
                            1:       cp = CP_MAX1 + 24'd1;
                            2:       cp = CP_MAX2;
                            3:       cp = CP_MAX3;
                            4:       cp = CP_MAX;
                            5:       cp = CP_MAX + 24'd1;
                            6:       cp = CP_SUR_LO - 24'd1;
                            default: cp = CP_SUR_HI + 24'd1;
                        endcase
                    end
                endcase
                w = 1;
                while (w < 6 && (cp >> (4 * w)) != 0)
                    w++;
                n = $urandom_range(0, 19);
                if (n == 0)
                    w = 0;
                else if (n == 1)
                    w = 7;
                else if (n < 6)
                    w = $urandom_range(w, 6);
                for (int i = w - 1; i >= 0; i--)
                    text_q.push_back(hex_char(int'((cp >> (4 * i)) & 24'hF)));
                n = $urandom_range(0, 19);
                if (n == 0)
                    text_q.push_back(8'($urandom_range(0, 255)));
                else if (n > 1)
                    text_q.push_back(CH_RBRACE);
            end
        end
        else
        begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_literal(bit calm);
        sed_in_t req;
        int      gap;
        foreach (text_q[i])
        begin
            req.char_byte      = text_q[i];
            req.last_in_string = (i == text_q.size() - 1);
            gap = (calm || hold_req || holding) ? 0 : pick_gap();
            if (gap > 0)
            begin
                chr_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            chr_valid <= 1'b1;
            chr_data  <= req;
            @(posedge clk);
            while (!chr_ready)
                @(posedge clk);
            @(negedge clk);
        end
        text_q.delete();
    endtask

    task automatic await_idle();
        chr_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chr_valid && chr_ready)
                sb.note_request(chr_data);
            if (dec_valid && dec_ready)
                sb.check_result(dec_data);
            if (cfg_valid && cfg_ready)
                sb.set_strict(cfg_data);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((chr_valid && chr_ready) || (dec_valid && dec_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : receiver
        int n;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                holding  = 1'b1;
                dec_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holding = 1'b0;
            end
            else
            begin
                if (dec_ready !== 1'b1)
                    dec_ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
                repeat (n) @(negedge clk);
                n = pick_gap();
                if (n > 0)
                begin
                    dec_ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int goal;
        int lits;
        int cut;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        add_text("\\q\\");
        send_literal(1'b0);
        add_text("\\u{10fFFF}");
        send_literal(1'b0);
        add_text("\\o4");
        send_literal(1'b0);
        add_text("\\u{");
        send_literal(1'b0);
        add_text("\\xz");
        send_literal(1'b0);

        for (int p = 0; p < 4; p++)
        begin
            await_idle();
            cfg_valid <= 1'b1;
            cfg_data  <= p[0];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;

            goal = sb.live_items + PHASE_ITEMS;
            lits = 0;
            while (sb.live_items < goal)
            begin
                if (p == 1 && lits == 10)
                    hold_req = 1'b1;
                if (p == 2 && lits == 15)
                    await_idle();
                repeat ($urandom_range(1, 5)) add_segment();
                if ($urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, text_q.size());
                    while (text_q.size() > cut)
                        void'(text_q.pop_back());
                end
                send_literal($urandom_range(0, 9) < 2);
                lits++;
            end
        end

        await_idle();
        repeat (16) @(negedge clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
